[rtl/core/iprl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iprl_pkg
// Shared types and constants for the IPv4 range table lookup block.
// ----------------------------------------------------------------------------
package iprl_pkg;

	localparam int PREFIX_ENTRIES = 65536;
	localparam int PFX_AW         = 16;
	localparam int CNT_W          = 17;
	localparam int OP_W           = 2;
	localparam int SLOT_W         = 16;
	localparam int IP_W           = 32;
	localparam int START_W        = 16;
	localparam int OFFSET_W       = 24;
	localparam int LENGTH_W       = 16;
	localparam int INDEX_W        = 16;

	localparam logic [OP_W-1:0] OP_WRITE_PREFIX = 2'd0;
	localparam logic [OP_W-1:0] OP_WRITE_RECORD = 2'd1;
	localparam logic [OP_W-1:0] OP_LOOKUP       = 2'd2;

	typedef struct packed {
		logic [IP_W-1:0]     end_addr;
		logic [OFFSET_W-1:0] offset;
		logic [LENGTH_W-1:0] length;
	} rec_t;

endpackage

[rtl/core/iprl_prefix_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iprl_prefix_store
// Prefix index memory: first record number for each upper 16 address bits.
// ----------------------------------------------------------------------------
module iprl_prefix_store (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [iprl_pkg::PFX_AW-1:0] wr_addr,
	input  logic [iprl_pkg::START_W-1:0] wr_data,
	input  logic                        rd_en,
	input  logic [iprl_pkg::PFX_AW-1:0] rd_addr,
	output logic [iprl_pkg::START_W-1:0] rd_data
);
	import iprl_pkg::*;

	logic [START_W-1:0] mem [PREFIX_ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/core/iprl_record_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iprl_record_store
// Sorted record memory: end address, payload offset and length per record.
// ----------------------------------------------------------------------------
module iprl_record_store #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  iprl_pkg::rec_t      wr_data,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	output iprl_pkg::rec_t      rd_data
);
	import iprl_pkg::*;

	rec_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/core/ipv4_range_table_lookup.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_range_table_lookup
// Prefix-indexed scan of a sorted IPv4 range table.
// ----------------------------------------------------------------------------
//  channel | signals                          | moves
//  --------+----------------------------------+------------------------------
//  in      | in_valid / in_stall + 6 fields   | write prefix, write record,
//          |                                  | lookup request
//  out     | out_valid / out_stall + 4 fields | one result per lookup
//  cfg     | cfg_we / cfg_wdata               | record_count
//
//  Writes go straight to the memories when accepted. A lookup does one
//  prefix memory read, then one record memory read per cycle from the start
//  record until a match or the scan limit, then hands over the result.
//  One request is worked on at a time; the next is taken once the result sits
//  in the output register, even while that register is stalled.
//  Reset clears control and record_count only; memories hold garbage until
//  written, so there is no clearing pass.
// ----------------------------------------------------------------------------
module ipv4_range_table_lookup #(
	parameter int MAX_RECORDS = 65536
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          cfg_we,
	input  logic [iprl_pkg::CNT_W-1:0]    cfg_wdata,

	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [iprl_pkg::OP_W-1:0]     operation,
	input  logic [iprl_pkg::SLOT_W-1:0]   slot,
	input  logic [iprl_pkg::IP_W-1:0]     ip_value,
	input  logic [iprl_pkg::START_W-1:0]  start_record,
	input  logic [iprl_pkg::OFFSET_W-1:0] payload_offset,
	input  logic [iprl_pkg::LENGTH_W-1:0] payload_length,

	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          found,
	output logic [iprl_pkg::INDEX_W-1:0]  match_index,
	output logic [iprl_pkg::OFFSET_W-1:0] match_offset,
	output logic [iprl_pkg::LENGTH_W-1:0] match_length
);
	import iprl_pkg::*;

	localparam int RIDX_W = $clog2(MAX_RECORDS);
	localparam int SCAN_W = (RIDX_W + 1 > CNT_W) ? RIDX_W + 1 : CNT_W;
	localparam logic [SCAN_W-1:0] MAX_LIM = SCAN_W'(MAX_RECORDS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PFX  = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]          state_q, state_d;
	logic [CNT_W-1:0]    count_q;
	logic [IP_W-1:0]     ip_q;
	logic [SCAN_W-1:0]   scan_q, scan_d;
	logic                res_found_q, res_found_d;
	logic [INDEX_W-1:0]  res_index_q, res_index_d;
	logic [OFFSET_W-1:0] res_offset_q, res_offset_d;
	logic [LENGTH_W-1:0] res_length_q, res_length_d;
	logic                out_valid_q;

	logic                in_acc;
	logic                out_free;
	logic [SCAN_W-1:0]   count_ext, limit;
	logic [SCAN_W-1:0]   slot_ext, start_ext, scan_next;

	logic                pfx_we, pfx_re;
	logic [START_W-1:0]  pfx_rdata;
	logic                rec_we, rec_re;
	logic [RIDX_W-1:0]   rec_raddr;
	rec_t                rec_wdata, rec_rdata;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign count_ext = SCAN_W'(count_q);
	assign limit     = (count_ext > MAX_LIM) ? MAX_LIM : count_ext;
	assign slot_ext  = SCAN_W'(slot);
	assign start_ext = SCAN_W'(pfx_rdata);
	assign scan_next = scan_q + SCAN_W'(1);

	// writes go straight to the memories at acceptance
	assign pfx_we = in_acc && (operation == OP_WRITE_PREFIX);
	assign rec_we = in_acc && (operation == OP_WRITE_RECORD) && (slot_ext < MAX_LIM);
	assign pfx_re = in_acc && (operation == OP_LOOKUP);

	assign rec_wdata.end_addr = ip_value;
	assign rec_wdata.offset   = payload_offset;
	assign rec_wdata.length   = payload_length;

	iprl_prefix_store u_pfx (
		.clk     (clk),
		.wr_en   (pfx_we),
		.wr_addr (slot),
		.wr_data (start_record),
		.rd_en   (pfx_re),
		.rd_addr (ip_value[IP_W-1 -: PFX_AW]),
		.rd_data (pfx_rdata)
	);

	iprl_record_store #(
		.DEPTH (MAX_RECORDS),
		.AW    (RIDX_W)
	) u_rec (
		.clk     (clk),
		.wr_en   (rec_we),
		.wr_addr (slot_ext[RIDX_W-1:0]),
		.wr_data (rec_wdata),
		.rd_en   (rec_re),
		.rd_addr (rec_raddr),
		.rd_data (rec_rdata)
	);

	always_comb begin
		state_d      = state_q;
		scan_d       = scan_q;
		res_found_d  = res_found_q;
		res_index_d  = res_index_q;
		res_offset_d = res_offset_q;
		res_length_d = res_length_q;
		rec_re       = 1'b0;
		rec_raddr    = scan_next[RIDX_W-1:0];

		unique case (state_q)
			ST_IDLE: begin
				if (pfx_re) begin
					state_d = ST_PFX;
				end
			end
			ST_PFX: begin
				res_found_d  = 1'b0;
				res_index_d  = '0;
				res_offset_d = '0;
				res_length_d = '0;
				if (start_ext < limit) begin
					rec_re    = 1'b1;
					rec_raddr = start_ext[RIDX_W-1:0];
					scan_d    = start_ext;
					state_d   = ST_SCAN;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_SCAN: begin
				// rec_rdata belongs to scan_q; next record is fetched ahead
				if (rec_rdata.end_addr >= ip_q) begin
					res_found_d  = 1'b1;
					res_index_d  = scan_q[INDEX_W-1:0];
					res_offset_d = rec_rdata.offset;
					res_length_d = rec_rdata.length;
					state_d      = ST_DONE;
				end else if (scan_next < limit) begin
					rec_re = 1'b1;
					scan_d = scan_next;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				count_q <= cfg_wdata;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pfx_re) begin
			ip_q <= ip_value;
		end
		scan_q       <= scan_d;
		res_found_q  <= res_found_d;
		res_index_q  <= res_index_d;
		res_offset_q <= res_offset_d;
		res_length_q <= res_length_d;
		if (state_q == ST_DONE && out_free) begin
			found        <= res_found_q;
			match_index  <= res_index_q;
			match_offset <= res_offset_q;
			match_length <= res_length_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ipv4_range_table_lookup. A short table of directed
// requests is walked first, then random phases that load a small sorted record
// block and its prefix entries and fire lookups at it, under several record
// counts and idling patterns. Results are compared to typed or predicted answers.
// ----------------------------------------------------------------------------
module testbench;
	import iprl_pkg::*;

	localparam logic [OP_W-1:0]  OP_UNUSED     = 2'd3;
	localparam int               REC_DEPTH     = 65536;
	localparam logic [CNT_W-1:0] COUNT_CEIL    = 17'd65536;
	localparam int               SCAN_CAP      = 64;
	localparam int               SETTLE_CYCLES = 8;
	localparam int               RANDOM_ITEMS  = 1050;
	localparam int               SUB_PHASES    = 9;

	typedef struct packed {
		logic                found;
		logic [INDEX_W-1:0]  index;
		logic [OFFSET_W-1:0] offset;
		logic [LENGTH_W-1:0] length;
	} answer_t;

	typedef struct packed {
		logic [OP_W-1:0]     op;
		logic [SLOT_W-1:0]   slot;
		logic [IP_W-1:0]     ip;
		logic [START_W-1:0]  start;
		logic [OFFSET_W-1:0] offset;
		logic [LENGTH_W-1:0] length;
	} request_t;

	typedef enum logic {ROW_REQ, ROW_COUNT} row_kind_t;

	typedef struct {
		row_kind_t        kind;
		request_t         req;
		logic [CNT_W-1:0] count;
		bit               typed;
		answer_t          answer;
	} dir_row_t;

	logic                clk            = 1'b0;
	logic                arst_n         = 1'b0;
	logic                cfg_we         = 1'b0;
	logic [CNT_W-1:0]    cfg_wdata      = '0;
	logic                in_valid       = 1'b0;
	logic                in_stall;
	logic [OP_W-1:0]     operation      = '0;
	logic [SLOT_W-1:0]   slot           = '0;
	logic [IP_W-1:0]     ip_value       = '0;
	logic [START_W-1:0]  start_record   = '0;
	logic [OFFSET_W-1:0] payload_offset = '0;
	logic [LENGTH_W-1:0] payload_length = '0;
	logic                out_valid;
	logic                out_stall      = 1'b0;
	logic                found;
	logic [INDEX_W-1:0]  match_index;
	logic [OFFSET_W-1:0] match_offset;
	logic [LENGTH_W-1:0] match_length;

	ipv4_range_table_lookup uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.slot           (slot),
		.ip_value       (ip_value),
		.start_record   (start_record),
		.payload_offset (payload_offset),
		.payload_length (payload_length),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.found          (found),
		.match_index    (match_index),
		.match_offset   (match_offset),
		.match_length   (match_length)
	);

	// shadow copy of the block's tables and register
	logic [START_W-1:0]  pfx_start_tab [REC_DEPTH];
	bit                  pfx_written   [REC_DEPTH];
	logic [IP_W-1:0]     rec_end_tab   [REC_DEPTH];
	logic [OFFSET_W-1:0] rec_off_tab   [REC_DEPTH];
	logic [LENGTH_W-1:0] rec_len_tab   [REC_DEPTH];
	bit                  rec_written   [REC_DEPTH];
	logic [CNT_W-1:0]    count_reg = '0;

	answer_t  answers_due[$];
	dir_row_t dir_rows[$];
	int       error_count = 0;
	int       send_idle   = 0;
	int       recv_idle   = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("testbench: done, errors");
		$finish;
	end

	function automatic int scan_limit();
		return (count_reg > COUNT_CEIL) ? REC_DEPTH : int'(count_reg);
	endfunction

	function automatic answer_t lookup_answer(logic [IP_W-1:0] ip);
		answer_t a;
		int      i;
		int      lim;
		a   = '0;
		lim = scan_limit();
		i   = int'(pfx_start_tab[ip[31:16]]);
		while (i < lim) begin
			if (rec_end_tab[i] >= ip) begin
				a.found  = 1'b1;
				a.index  = INDEX_W'(i);
				a.offset = rec_off_tab[i];
				a.length = rec_len_tab[i];
				return a;
			end
			i++;
		end
		return a;
	endfunction

	// a lookup may only touch entries that were written, and stays short
	function automatic bit lookup_safe(logic [IP_W-1:0] ip);
		int i;
		int lim;
		int steps;
		if (!pfx_written[ip[31:16]])
			return 1'b0;
		lim   = scan_limit();
		i     = int'(pfx_start_tab[ip[31:16]]);
		steps = 0;
		while (i < lim) begin
			if (!rec_written[i] || steps == SCAN_CAP)
				return 1'b0;
			if (rec_end_tab[i] >= ip)
				return 1'b1;
			i++;
			steps++;
		end
		return 1'b1;
	endfunction

	task automatic report_error(string msg);
		$display("testbench: mismatch at %0t: %s", $time, msg);
		error_count++;
	endtask

	task automatic take_request(request_t r, bit typed, answer_t typed_answer);
		case (r.op)
			OP_WRITE_PREFIX: begin
				pfx_start_tab[r.slot] = r.start;
				pfx_written[r.slot]   = 1'b1;
			end
			OP_WRITE_RECORD: begin
				rec_end_tab[r.slot] = r.ip;
				rec_off_tab[r.slot] = r.offset;
				rec_len_tab[r.slot] = r.length;
				rec_written[r.slot] = 1'b1;
			end
			OP_LOOKUP: begin
				answers_due.push_back(typed ? typed_answer : lookup_answer(r.ip));
			end
			default: ;
		endcase
	endtask

	task automatic send_request(request_t r, bit typed, answer_t typed_answer);
		if ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
		end
		in_valid       <= 1'b1;
		operation      <= r.op;
		slot           <= r.slot;
		ip_value       <= r.ip;
		start_record   <= r.start;
		payload_offset <= r.offset;
		payload_length <= r.length;
		do @(posedge clk); while (in_stall);
		take_request(r, typed, typed_answer);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_count(logic [CNT_W-1:0] v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		count_reg  = v;
	endtask

	function automatic void add_req(logic [OP_W-1:0] op, logic [SLOT_W-1:0] s,
			logic [IP_W-1:0] ip, logic [START_W-1:0] st, logic [OFFSET_W-1:0] off,
			logic [LENGTH_W-1:0] len);
		dir_row_t row;
		row.kind   = ROW_REQ;
		row.req    = '{op, s, ip, st, off, len};
		row.count  = '0;
		row.typed  = 1'b0;
		row.answer = '0;
		dir_rows.push_back(row);
	endfunction

	function automatic void add_lookup(logic [IP_W-1:0] ip, bit typed, answer_t a);
		dir_row_t row;
		row.kind   = ROW_REQ;
		row.req    = '{OP_LOOKUP, 16'h0, ip, 16'h0, 24'h0, 16'h0};
		row.count  = '0;
		row.typed  = typed;
		row.answer = a;
		dir_rows.push_back(row);
	endfunction

	function automatic void add_count(logic [CNT_W-1:0] v);
		dir_row_t row;
		row.kind   = ROW_COUNT;
		row.req    = '0;
		row.count  = v;
		row.typed  = 1'b0;
		row.answer = '0;
		dir_rows.push_back(row);
	endfunction

	function automatic void build_directed();
		add_req(OP_WRITE_PREFIX, 16'h0000, 32'h0, 16'h0000, 24'h0, 16'h0);
		// count still zero from reset: nothing to scan
		add_lookup(32'h0000_0000, 1'b1, '0);
		add_count(17'd4);
		add_req(OP_WRITE_RECORD, 16'd0, 32'h0000_0010, 16'h0, 24'h000000, 16'h0000);
		add_req(OP_WRITE_RECORD, 16'd1, 32'h0000_FFFF, 16'h0, 24'hFFFFFF, 16'hFFFF);
		add_req(OP_WRITE_RECORD, 16'd2, 32'h7FFF_FFFF, 16'h0, 24'h123456, 16'h0042);
		add_req(OP_WRITE_RECORD, 16'd3, 32'hFFFF_FFFF, 16'h0, 24'hABCDEF, 16'h8000);
		add_req(OP_WRITE_PREFIX, 16'hFFFF, 32'h0, 16'd3, 24'h0, 16'h0);
		add_req(OP_WRITE_PREFIX, 16'h8000, 32'h0, 16'd2, 24'h0, 16'h0);
		add_lookup(32'h0000_0000, 1'b1, '{1'b1, 16'd0, 24'h000000, 16'h0000});
		add_lookup(32'h0000_0011, 1'b1, '{1'b1, 16'd1, 24'hFFFFFF, 16'hFFFF});
		add_lookup(32'hFFFF_FFFF, 1'b1, '{1'b1, 16'd3, 24'hABCDEF, 16'h8000});
		add_lookup(32'h8000_0000, 1'b0, '0);
		// unused opcode with every field set: must be dropped silently
		add_req(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 24'hFFFFFF, 16'hFFFF);
		// start record past the scan limit
		add_req(OP_WRITE_PREFIX, 16'h1234, 32'h0, 16'hFFFF, 24'h0, 16'h0);
		add_lookup(32'h1234_5678, 1'b1, '0);
		// count above the table depth is clamped
		add_count(17'h1FFFF);
		add_lookup(32'hFFFF_FFFF, 1'b1, '{1'b1, 16'd3, 24'hABCDEF, 16'h8000});
		add_count(17'd3);
		add_lookup(32'h8000_0000, 1'b1, '0);
		add_lookup(32'hFFFF_0000, 1'b1, '0);
		add_req(OP_WRITE_RECORD, 16'd2, 32'h8000_0000, 16'h0, 24'h000000, 16'h0001);
		add_lookup(32'h8000_0000, 1'b0, '0);
	endfunction

	task automatic run_sub_phase(int phase, int quota);
		logic [IP_W-1:0]   ends[$];
		logic [SLOT_W-1:0] prefixes[$];
		logic [CNT_W-1:0]  count_pick;
		logic [IP_W-1:0]   ip;
		logic [SLOT_W-1:0] p;
		request_t          r;
		int                base;
		int                size;
		int                sent;
		int                j;
		int                k;
		int                tries;
		int                pick;
		bit                ok;
		size = $urandom_range(4, 24);
		base = (phase % 3 == 2) ? REC_DEPTH - size : $urandom_range(0, REC_DEPTH - size);
		for (j = 0; j < size; j++)
			ends.push_back($urandom);
		ends.sort();
		if ($urandom_range(0, 3) != 0)
			ends[size-1] = '1;

		case (phase)
			0: count_pick = CNT_W'(base + size);
			1: count_pick = '0;
			2: count_pick = COUNT_CEIL;
			3: count_pick = CNT_W'($urandom_range(base, base + size));
			4: count_pick = '1;
			5: count_pick = CNT_W'(REC_DEPTH - 1);
			6: count_pick = CNT_W'(base + size / 2);
			7: count_pick = CNT_W'($urandom);
			default: count_pick = CNT_W'(1);
		endcase
		write_count(count_pick);

		sent = 0;
		for (j = 0; j < size; j++) begin
			r = '{OP_WRITE_RECORD, SLOT_W'(base + j), ends[j], START_W'($urandom),
				OFFSET_W'($urandom), LENGTH_W'($urandom)};
			send_request(r, 1'b0, '0);
			sent++;
		end
		// well-formed prefix entries: first record that can cover the /16
		for (j = 0; j < size; j++) begin
			p = ends[j][31:16];
			k = 0;
			while (ends[k] < {p, 16'h0000})
				k++;
			r = '{OP_WRITE_PREFIX, p, IP_W'($urandom), START_W'(base + k),
				OFFSET_W'($urandom), LENGTH_W'($urandom)};
			send_request(r, 1'b0, '0);
			prefixes.push_back(p);
			sent++;
		end

		while (sent < quota) begin
			pick = $urandom_range(0, 99);
			r    = '{OP_WRITE_RECORD, 16'h0, IP_W'($urandom), START_W'($urandom),
				OFFSET_W'($urandom), LENGTH_W'($urandom)};
			if (pick < 60) begin
				ok = 1'b0;
				for (tries = 0; tries < 10 && !ok; tries++) begin
					k = $urandom_range(0, 9);
					if (k < 4)
						ip = {prefixes[$urandom_range(0, prefixes.size() - 1)],
							16'($urandom)};
					else if (k < 7)
						ip = ends[$urandom_range(0, size - 1)] + IP_W'($urandom_range(0, 1));
					else
						ip = $urandom;
					ok = lookup_safe(ip);
				end
				if (ok) begin
					r.op = OP_LOOKUP;
					r.ip = ip;
				end else begin
					// nothing safe to look up: rewrite a block record in place
					j      = $urandom_range(0, size - 1);
					r.slot = SLOT_W'(base + j);
					r.ip   = ends[j];
				end
			end else if (pick < 75) begin
				j      = $urandom_range(0, size - 1);
				r.slot = SLOT_W'(base + j);
				r.ip   = ends[j];
			end else if (pick < 85) begin
				r.slot = SLOT_W'($urandom);
			end else if (pick < 93) begin
				r.op = OP_WRITE_PREFIX;
				if ($urandom_range(0, 1) == 0) begin
					r.slot  = prefixes[$urandom_range(0, prefixes.size() - 1)];
					r.start = START_W'(base + $urandom_range(0, size - 1));
				end else begin
					r.slot = SLOT_W'($urandom);
					prefixes.push_back(r.slot);
				end
			end else begin
				r.op   = OP_UNUSED;
				r.slot = SLOT_W'($urandom);
			end
			send_request(r, 1'b0, '0);
			if (r.op != OP_UNUSED)
				sent++;
		end
	endtask

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_idle);
	end

	always @(posedge clk) begin : result_check
		answer_t got;
		answer_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {found, match_index, match_offset, match_length};
			if (answers_due.size() == 0) begin
				report_error("result with no lookup outstanding");
			end else begin
				want = answers_due.pop_front();
				if (got.found !== want.found)
					report_error($sformatf("found %b, want %b", got.found, want.found));
				if (got.index !== want.index)
					report_error($sformatf("match_index %h, want %h", got.index, want.index));
				if (got.offset !== want.offset)
					report_error($sformatf("match_offset %h, want %h",
						got.offset, want.offset));
				if (got.length !== want.length)
					report_error($sformatf("match_length %h, want %h",
						got.length, want.length));
			end
		end
	end

	initial begin : stimulus
		int phase;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle = 38;
		recv_idle = 53;
		build_directed();
		foreach (dir_rows[n]) begin
			if (dir_rows[n].kind == ROW_COUNT)
				write_count(dir_rows[n].count);
			else
				send_request(dir_rows[n].req, dir_rows[n].typed, dir_rows[n].answer);
		end

		for (phase = 0; phase < SUB_PHASES; phase++) begin
			case (phase / 3)
				0: begin
					send_idle = 38;
					recv_idle = 53;
				end
				1: begin
					send_idle = 53;
					recv_idle = 38;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			run_sub_phase(phase, RANDOM_ITEMS / SUB_PHASES);
		end

		drain();
		if (error_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
